FILE: design/vsfe_pkg.sv
// Package: shared types, constants and command codes for the voxel shape fill engine.
package vsfe_pkg;
    localparam int unsigned DEF_MAX_X = 32;
    localparam int unsigned DEF_MAX_Y = 32;
    localparam int unsigned DEF_MAX_Z = 32;

    localparam int unsigned CMD_W   = 4;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned REACH_W = 6;
    localparam int unsigned SIZE_W  = 6;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_READ = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd6;

    // shape kind = command >> 1
    localparam logic [2:0] KIND_VOXEL = 3'd0;
    localparam logic [2:0] KIND_BOX   = 3'd1;
    localparam logic [2:0] KIND_SPH   = 3'd2;
    localparam logic [2:0] KIND_ELL   = 3'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture command beat
        logic clr_step; // clearing sweep: write zero at scan address
        logic scan_rst; // reset scan counters
        logic scan_adv; // advance scan counters
        logic rd_issue; // latch whether the command position lies in the grid
        logic rd_take;  // latch read data into result
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic is_read;
        logic is_bad;
    } t_sts;
endpackage

FILE: design/vsfe_ctrl.sv
// Controller: sequences reset clear, command scan, read and result handoff.
module vsfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    input  vsfe_pkg::t_sts  i_sts,
    output vsfe_pkg::t_ctl  o_ctl
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_DEC   = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_FLUSH = 8'b00010000,
        S_DRAIN = 8'b00100000,
        S_READ  = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                o_ctl.scan_adv = 1'b1;
                if (i_sts.scan_last) begin
                    o_ctl.scan_rst = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    o_ctl.scan_rst = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_bad) begin
                    n_state = S_DONE;
                end else if (i_sts.is_read) begin
                    o_ctl.rd_issue = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_adv = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            // the flush and drain states let the last scanned voxel reach the write and count stage
            S_FLUSH: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_READ: begin
                o_ctl.rd_take = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

FILE: design/vsfe_datapath.sv
// Datapath: voxel store, scan counters, shape test pipeline and result register.
module vsfe_datapath #(
    parameter int unsigned MAX_X = vsfe_pkg::DEF_MAX_X,
    parameter int unsigned MAX_Y = vsfe_pkg::DEF_MAX_Y,
    parameter int unsigned MAX_Z = vsfe_pkg::DEF_MAX_Z
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vsfe_pkg::t_ctl                     i_ctl,
    output vsfe_pkg::t_sts                     o_sts,
    input  logic [vsfe_pkg::CMD_W-1:0]         i_command,
    input  logic signed [vsfe_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [vsfe_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [vsfe_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [vsfe_pkg::POS_W-1:0]  i_end_x,
    input  logic signed [vsfe_pkg::POS_W-1:0]  i_end_y,
    input  logic signed [vsfe_pkg::POS_W-1:0]  i_end_z,
    input  logic [vsfe_pkg::REACH_W-1:0]       i_reach_x,
    input  logic [vsfe_pkg::REACH_W-1:0]       i_reach_y,
    input  logic [vsfe_pkg::REACH_W-1:0]       i_reach_z,
    input  logic [vsfe_pkg::SIZE_W-1:0]        i_size_x,
    input  logic [vsfe_pkg::SIZE_W-1:0]        i_size_y,
    input  logic [vsfe_pkg::SIZE_W-1:0]        i_size_z,
    input  logic [4*vsfe_pkg::COLOR_W-1:0]     i_color,
    output logic                               o_voxel_on,
    output logic [4*vsfe_pkg::COLOR_W-1:0]     o_color,
    output logic [vsfe_pkg::COUNT_W-1:0]       o_touched_count
);
    localparam int unsigned XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int unsigned YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int unsigned ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int unsigned AW = XW + YW + ZW;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned CW = vsfe_pkg::COLOR_W;
    localparam int unsigned PW = vsfe_pkg::POS_W;
    localparam int unsigned SW = vsfe_pkg::SIZE_W;
    localparam int unsigned DW = PW + 1;      // coordinate difference
    localparam int unsigned QW = 2 * DW;      // square of difference
    localparam int unsigned AQ = 12;          // reach squared
    localparam int unsigned LW = 48;          // ellipsoid sums
    localparam logic [SW:0] MXX = (SW+1)'(MAX_X);
    localparam logic [SW:0] MXY = (SW+1)'(MAX_Y);
    localparam logic [SW:0] MXZ = (SW+1)'(MAX_Z);

    // store: RGBA; entry index is x,y,z packed
    logic [4*CW-1:0] r_mem [DEPTH];

    // captured command
    logic [vsfe_pkg::CMD_W-1:0] r_cmd;
    logic signed [PW-1:0] r_px, r_py, r_pz, r_ex, r_ey, r_ez;
    logic [vsfe_pkg::REACH_W-1:0] r_rx, r_ry, r_rz;
    logic [SW:0] r_nx, r_ny, r_nz;

    // scan counters (extent exclusive compare done on wide values)
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;

    logic [SW:0] n_nx, n_ny, n_nz;
    always_comb begin
        logic [SW:0] sx, sy, sz;
        sx = {1'b0, i_size_x};
        sy = {1'b0, i_size_y};
        sz = {1'b0, i_size_z};
        n_nx = (sx < MXX) ? sx : MXX;
        n_ny = (sy < MXY) ? sy : MXY;
        n_nz = (sz < MXZ) ? sz : MXZ;
    end

    logic w_xl, w_yl, w_zl, w_empty;
    assign w_xl = ({{(SW+1-XW){1'b0}}, r_x} + 1'b1) >= r_nx;
    assign w_yl = ({{(SW+1-YW){1'b0}}, r_y} + 1'b1) >= r_ny;
    assign w_zl = ({{(SW+1-ZW){1'b0}}, r_z} + 1'b1) >= r_nz;
    assign w_empty = (r_nx == '0) || (r_ny == '0) || (r_nz == '0);

    // clearing sweep walks the full address space
    logic w_full_last;
    assign w_full_last = (r_x == XW'(MAX_X - 1)) && (r_y == YW'(MAX_Y - 1))
                      && (r_z == ZW'(MAX_Z - 1));

    assign o_sts.scan_last = i_ctl.clr_step ? w_full_last
                           : (w_empty || (w_xl && w_yl && w_zl));
    assign o_sts.is_read = (r_cmd == vsfe_pkg::CMD_READ);
    assign o_sts.is_bad  = (r_cmd > vsfe_pkg::CMD_READ);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_px <= i_pos_x; r_py <= i_pos_y; r_pz <= i_pos_z;
            r_ex <= i_end_x; r_ey <= i_end_y; r_ez <= i_end_z;
            r_rx <= i_reach_x; r_ry <= i_reach_y; r_rz <= i_reach_z;
            r_nx <= n_nx; r_ny <= n_ny; r_nz <= n_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.scan_rst) begin
            r_x <= '0; r_y <= '0; r_z <= '0;
        end else if (i_ctl.scan_adv) begin
            if (i_ctl.clr_step) begin
                if (r_z == ZW'(MAX_Z - 1)) begin
                    r_z <= '0;
                    if (r_y == YW'(MAX_Y - 1)) begin
                        r_y <= '0;
                        r_x <= r_x + 1'b1;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end else begin
                    r_z <= r_z + 1'b1;
                end
            end else if (w_zl) begin
                r_z <= '0;
                if (w_yl) begin
                    r_y <= '0;
                    r_x <= r_x + 1'b1;
                end else begin
                    r_y <= r_y + 1'b1;
                end
            end else begin
                r_z <= r_z + 1'b1;
            end
        end
    end

    // ---- stage 1: differences, squares, box and voxel tests
    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    assign w_dx = $signed({1'b0, r_x}) - DW'(r_px);
    assign w_dy = $signed({1'b0, r_y}) - DW'(r_py);
    assign w_dz = $signed({1'b0, r_z}) - DW'(r_pz);

    logic w_box;
    assign w_box = ($signed({1'b0, r_x}) <= DW'(r_ex)) && (w_dx >= 0)
                && ($signed({1'b0, r_y}) <= DW'(r_ey)) && (w_dy >= 0)
                && ($signed({1'b0, r_z}) <= DW'(r_ez)) && (w_dz >= 0);

    logic r1_v, r1_box, r1_vox;
    logic [QW-1:0] r1_qx, r1_qy, r1_qz;
    logic [AW-1:0] r1_adr;
    logic [AQ-1:0] r_ax, r_ay, r_az;
    logic [2*AQ-1:0] r_axy, r_axz, r_ayz;
    logic [3*AQ-1:0] r_axyz;

    // reach products: constant over a command, settled during decode/first beats
    always_ff @(posedge i_clk) begin
        r_ax <= AQ'(r_rx * r_rx);
        r_ay <= AQ'(r_ry * r_ry);
        r_az <= AQ'(r_rz * r_rz);
        r_axy <= r_ax * r_ay;
        r_axz <= r_ax * r_az;
        r_ayz <= r_ay * r_az;
        r_axyz <= r_axy * r_az;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_ctl.scan_adv && !i_ctl.clr_step && !w_empty;
        end
        r1_box <= w_box;
        r1_vox <= (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
        r1_qx <= QW'(w_dx * w_dx);
        r1_qy <= QW'(w_dy * w_dy);
        r1_qz <= QW'(w_dz * w_dz);
        r1_adr <= {r_x, r_y, r_z};
    end

    // ---- stage 2: products with reach terms
    logic r2_v, r2_box, r2_vox;
    logic [QW:0] r2_sph;
    logic [LW-1:0] r2_ex, r2_ey, r2_ez;
    logic [AW-1:0] r2_adr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_box <= r1_box;
        r2_vox <= r1_vox;
        r2_sph <= (QW+1)'(r1_qx) + (QW+1)'(r1_qy) + (QW+1)'(r1_qz);
        r2_ex <= LW'(r1_qx * r_ayz);
        r2_ey <= LW'(r1_qy * r_axz);
        r2_ez <= LW'(r1_qz * r_axy);
        r2_adr <= r1_adr;
    end

    // ---- stage 3: compare, select, write
    logic w_hit, w_sph, w_ell;
    logic [2:0] w_kind;
    assign w_kind = r_cmd[3:1];
    assign w_sph = ({{(QW+1-AQ){1'b0}}, r_ax} > r2_sph);
    assign w_ell = (r_rx != '0) && (r_ry != '0) && (r_rz != '0)
                && ((r2_ex + r2_ey + r2_ez) < LW'(r_axyz));
    always_comb begin
        case (w_kind)
            vsfe_pkg::KIND_VOXEL: w_hit = r2_vox;
            vsfe_pkg::KIND_BOX:   w_hit = r2_box;
            vsfe_pkg::KIND_SPH:   w_hit = w_sph;
            default:              w_hit = w_ell;
        endcase
    end

    logic w_wr, w_put;
    logic [AW-1:0] w_wadr;
    logic [4*CW-1:0] r_rdat;
    assign w_put = !r_cmd[0];
    assign w_wr = i_ctl.clr_step || (r2_v && w_hit);
    assign w_wadr = i_ctl.clr_step ? {r_x, r_y, r_z} : r2_adr;

    // on flags kept apart so a cut leaves colour untouched
    logic r_on [DEPTH];
    logic r_ron;
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step || (w_wr && w_put)) begin
            r_mem[w_wadr] <= i_ctl.clr_step ? '0 : i_color;
        end
        if (w_wr) begin
            r_on[w_wadr] <= !i_ctl.clr_step && w_put;
        end
        r_rdat <= r_mem[{r_px[XW-1:0], r_py[YW-1:0], r_pz[ZW-1:0]}];
        r_ron  <= r_on[{r_px[XW-1:0], r_py[YW-1:0], r_pz[ZW-1:0]}];
    end

    // result
    logic w_rd_in;
    assign w_rd_in = (r_px >= 0) && (r_py >= 0) && (r_pz >= 0)
                  && ($signed({1'b0, r_nx}) > DW'(r_px))
                  && ($signed({1'b0, r_ny}) > DW'(r_py))
                  && ($signed({1'b0, r_nz}) > DW'(r_pz));
    logic r_rd_ok;
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_issue) r_rd_ok <= w_rd_in;
        if (i_ctl.load) begin
            o_voxel_on <= 1'b0;
            o_color <= '0;
            o_touched_count <= '0;
        end else begin
            if (i_ctl.rd_take && r_rd_ok) begin
                o_voxel_on <= r_ron;
                o_color <= r_rdat;
            end
            if (r2_v && w_hit && (o_touched_count != '1)) begin
                o_touched_count <= o_touched_count + 1'b1;
            end
        end
    end
endmodule

FILE: design/voxel_shape_fill_engine.sv
// Top level: voxel shape fill engine with stream ports and register write port.
// Command flow: voxel/box/sphere/ellipsoid commands scan the whole clipped grid
//   through decode, scan, pipeline flush and drain, and result; a read goes through
//   decode, read and result; an unknown command goes through decode and result.
// One command at a time: a new beat is accepted only after the result beat is taken.
// Reset: synchronous active low; then a clearing sweep over the whole grid
//   zeroes the store before the first beat is accepted.
module voxel_shape_fill_engine #(
    parameter int unsigned MAX_X = vsfe_pkg::DEF_MAX_X,
    parameter int unsigned MAX_Y = vsfe_pkg::DEF_MAX_Y,
    parameter int unsigned MAX_Z = vsfe_pkg::DEF_MAX_Z
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[3:0], pos_x[10:4], pos_y[17:11], pos_z[24:18], end_x[31:25],
    // end_y[38:32], end_z[45:39], reach_x[51:46], reach_y[57:52], reach_z[63:58]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // voxel_on[0], out_red[8:1], out_green[16:9], out_blue[24:17],
    // out_alpha[32:25], touched_count[48:33], zero fill [55:49]
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    // configuration registers, always writable
    logic [5:0] r_size_x, r_size_y, r_size_z;
    logic [7:0] r_red, r_green, r_blue, r_alpha;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 6'd32; r_size_y <= 6'd32; r_size_z <= 6'd32;
            r_red <= 8'hFF; r_green <= 8'hFF; r_blue <= 8'hFF; r_alpha <= 8'hFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vsfe_pkg::REG_SIZE_X: r_size_x <= i_cfg_data[5:0];
                vsfe_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data[5:0];
                vsfe_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data[5:0];
                vsfe_pkg::REG_RED:    r_red    <= i_cfg_data;
                vsfe_pkg::REG_GREEN:  r_green  <= i_cfg_data;
                vsfe_pkg::REG_BLUE:   r_blue   <= i_cfg_data;
                vsfe_pkg::REG_ALPHA:  r_alpha  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vsfe_pkg::t_ctl w_ctl;
    vsfe_pkg::t_sts w_sts;

    vsfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    logic        w_on;
    logic [31:0] w_color;
    logic [15:0] w_count;

    vsfe_datapath #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_command       (s_axis_tdata[3:0]),
        .i_pos_x         (s_axis_tdata[10:4]),
        .i_pos_y         (s_axis_tdata[17:11]),
        .i_pos_z         (s_axis_tdata[24:18]),
        .i_end_x         (s_axis_tdata[31:25]),
        .i_end_y         (s_axis_tdata[38:32]),
        .i_end_z         (s_axis_tdata[45:39]),
        .i_reach_x       (s_axis_tdata[51:46]),
        .i_reach_y       (s_axis_tdata[57:52]),
        .i_reach_z       (s_axis_tdata[63:58]),
        .i_size_x        (r_size_x),
        .i_size_y        (r_size_y),
        .i_size_z        (r_size_z),
        .i_color         ({r_alpha, r_blue, r_green, r_red}),
        .o_voxel_on      (w_on),
        .o_color         (w_color),
        .o_touched_count (w_count)
    );

    assign m_axis_tdata = {7'd0, w_count, w_color, w_on};
endmodule

FILE: sim/tb_vsfe_cmd_pkg.sv
// Command codes used by the stimulus of the voxel shape fill engine testbench.
package tb_vsfe_cmd_pkg;
    typedef enum logic [3:0] {
        CMD_PUT_VOXEL     = 4'd0,
        CMD_CUT_VOXEL     = 4'd1,
        CMD_PUT_BOX       = 4'd2,
        CMD_CUT_BOX       = 4'd3,
        CMD_PUT_SPHERE    = 4'd4,
        CMD_CUT_SPHERE    = 4'd5,
        CMD_PUT_ELLIPSOID = 4'd6,
        CMD_CUT_ELLIPSOID = 4'd7,
        CMD_READ_VOXEL    = 4'd8,
        CMD_UNKNOWN_LO    = 4'd9,
        CMD_UNKNOWN_HI    = 4'd15
    } t_cmd;
endpackage

FILE: sim/vsfe_checker.sv
// Checker: watches the engine's channels, predicts every result and compares it.
module vsfe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [63:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [55:0] i_m_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_pending,
    output int          o_errors
);
    localparam int GRID = 32;

    typedef struct {
        logic        on;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] touched;
    } t_voxel_result;

    logic       vox_on    [GRID*GRID*GRID];
    logic [7:0] vox_red   [GRID*GRID*GRID];
    logic [7:0] vox_green [GRID*GRID*GRID];
    logic [7:0] vox_blue  [GRID*GRID*GRID];
    logic [7:0] vox_alpha [GRID*GRID*GRID];

    logic [5:0] ext_x, ext_y, ext_z;
    logic [7:0] pen_red, pen_green, pen_blue, pen_alpha;

    t_voxel_result expected_results[$];
    int errors;

    assign o_pending = expected_results.size();
    assign o_errors  = errors;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic int clip(logic [5:0] s);
        return (s > GRID) ? GRID : int'(s);
    endfunction

    // Applies one command to the shadow store and returns what the engine should answer.
    function automatic t_voxel_result run_command(logic [63:0] d);
        t_voxel_result res = '{default: '0};
        logic [3:0] cmd = d[3:0];
        int px = $signed(d[10:4]);
        int py = $signed(d[17:11]);
        int pz = $signed(d[24:18]);
        int ex = $signed(d[31:25]);
        int ey = $signed(d[38:32]);
        int ez = $signed(d[45:39]);
        longint rx = d[51:46];
        longint ry = d[57:52];
        longint rz = d[63:58];
        int nx = clip(ext_x);
        int ny = clip(ext_y);
        int nz = clip(ext_z);
        logic [2:0] kind = cmd[3:1];
        logic put_op = !cmd[0];
        int cnt = 0;
        int idx;
        longint dx, dy, dz, lhs, ax, ay, az;
        logic hit;
        if (cmd == vsfe_pkg::CMD_READ) begin
            if (px >= 0 && py >= 0 && pz >= 0 && px < nx && py < ny && pz < nz) begin
                idx = (px * GRID + py) * GRID + pz;
                res.on    = vox_on[idx];
                res.red   = vox_red[idx];
                res.green = vox_green[idx];
                res.blue  = vox_blue[idx];
                res.alpha = vox_alpha[idx];
            end
            return res;
        end
        if (cmd > vsfe_pkg::CMD_READ) return res;
        for (int x = 0; x < nx; x++)
            for (int y = 0; y < ny; y++)
                for (int z = 0; z < nz; z++) begin
                    dx = x - px;
                    dy = y - py;
                    dz = z - pz;
                    case (kind)
                        vsfe_pkg::KIND_VOXEL: hit = (dx == 0) && (dy == 0) && (dz == 0);
                        vsfe_pkg::KIND_BOX: hit = x >= px && x <= ex && y >= py &&
                                                  y <= ey && z >= pz && z <= ez;
                        vsfe_pkg::KIND_SPH: hit = (dx*dx + dy*dy + dz*dz) < rx*rx;
                        default: begin
                            ax = rx*rx; ay = ry*ry; az = rz*rz;
                            lhs = dx*dx*ay*az + dy*dy*ax*az + dz*dz*ax*ay;
                            hit = (rx != 0) && (ry != 0) && (rz != 0) && (lhs < ax*ay*az);
                        end
                    endcase
                    if (hit) begin
                        idx = (x * GRID + y) * GRID + z;
                        vox_on[idx] = put_op;
                        // a cut keeps the stored color
                        if (put_op) begin
                            vox_red[idx]   = pen_red;
                            vox_green[idx] = pen_green;
                            vox_blue[idx]  = pen_blue;
                            vox_alpha[idx] = pen_alpha;
                        end
                        if (cnt < 65535) cnt++;
                    end
                end
        res.touched = cnt[15:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_voxel_result want;
        t_voxel_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < GRID*GRID*GRID; i++) begin
                vox_on[i] = 1'b0;
                vox_red[i] = '0; vox_green[i] = '0; vox_blue[i] = '0; vox_alpha[i] = '0;
            end
            ext_x = 6'd32; ext_y = 6'd32; ext_z = 6'd32;
            pen_red = 8'd255; pen_green = 8'd255; pen_blue = 8'd255; pen_alpha = 8'd255;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vsfe_pkg::REG_SIZE_X: ext_x = i_cfg_data[5:0];
                    vsfe_pkg::REG_SIZE_Y: ext_y = i_cfg_data[5:0];
                    vsfe_pkg::REG_SIZE_Z: ext_z = i_cfg_data[5:0];
                    vsfe_pkg::REG_RED:    pen_red   = i_cfg_data;
                    vsfe_pkg::REG_GREEN:  pen_green = i_cfg_data;
                    vsfe_pkg::REG_BLUE:   pen_blue  = i_cfg_data;
                    vsfe_pkg::REG_ALPHA:  pen_alpha = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready)
                expected_results.push_back(run_command(i_s_data));
            if (i_m_valid && i_m_ready) begin
                got.on      = i_m_data[0];
                got.red     = i_m_data[8:1];
                got.green   = i_m_data[16:9];
                got.blue    = i_m_data[24:17];
                got.alpha   = i_m_data[32:25];
                got.touched = i_m_data[48:33];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.on !== want.on) report_mismatch("voxel_on", got.on, want.on);
                    if (got.red !== want.red) report_mismatch("out_red", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("out_green", got.green, want.green);
                    if (got.blue !== want.blue)
                        report_mismatch("out_blue", got.blue, want.blue);
                    if (got.alpha !== want.alpha)
                        report_mismatch("out_alpha", got.alpha, want.alpha);
                    if (got.touched !== want.touched)
                        report_mismatch("touched_count", got.touched, want.touched);
                    if (i_m_data[55:49] !== '0) report_mismatch("zero fill", i_m_data[55:49], 0);
                end
            end
        end
    end

    initial errors = 0;
endmodule

FILE: sim/tb_voxel_shape_fill_engine.sv
// Testbench top: drives commands and register writes into the engine and gives the verdict.
module tb_voxel_shape_fill_engine;
    // slowest run: reset sweep plus a handful of full-grid scans, plus stalls
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    int pending_results;
    int error_count;
    int cycle_count;
    logic calm;     // no gaps and no stalls while set
    int stall_left;

    voxel_shape_fill_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    vsfe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending_results), .o_errors(error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 24) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(20, 80);
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] pack_cmd(
        tb_vsfe_cmd_pkg::t_cmd cmd, int px, int py, int pz, int ex, int ey, int ez,
        int rx, int ry, int rz);
        logic [6:0] cpx = px[6:0], cpy = py[6:0], cpz = pz[6:0];
        logic [6:0] cex = ex[6:0], cey = ey[6:0], cez = ez[6:0];
        logic [5:0] crx = rx[5:0], cry = ry[5:0], crz = rz[5:0];
        return {crz, cry, crx, cez, cey, cex, cpz, cpy, cpx, cmd};
    endfunction

    function automatic int gap_cycles();
        if (calm) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // one command beat; valid stays high into the next beat when no gap follows
    task automatic send_command(input logic [63:0] d);
        int gap;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = gap_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz);
        write_reg(vsfe_pkg::REG_SIZE_X, sx[7:0]);
        write_reg(vsfe_pkg::REG_SIZE_Y, sy[7:0]);
        write_reg(vsfe_pkg::REG_SIZE_Z, sz[7:0]);
    endtask

    task automatic set_pen(input int r, input int g, input int b, input int a);
        write_reg(vsfe_pkg::REG_RED, r[7:0]);
        write_reg(vsfe_pkg::REG_GREEN, g[7:0]);
        write_reg(vsfe_pkg::REG_BLUE, b[7:0]);
        write_reg(vsfe_pkg::REG_ALPHA, a[7:0]);
    endtask

    // coordinate near the used grid, sometimes anywhere in the 7-bit range
    function automatic int near_coord(int n);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
        return int'($urandom_range(0, n + 3)) - 2;
    endfunction

    function automatic int pick_reach();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, 5);
    endfunction

    task automatic random_command(input int n);
        tb_vsfe_cmd_pkg::t_cmd cmd;
        int px, py, pz, ex, ey, ez;
        px = near_coord(n); py = near_coord(n); pz = near_coord(n);
        if ($urandom_range(0, 9) == 0) cmd = tb_vsfe_cmd_pkg::t_cmd'($urandom_range(0, 15));
        else cmd = tb_vsfe_cmd_pkg::t_cmd'($urandom_range(0, 8));
        // mostly well-formed boxes, a few reversed or wild
        if ($urandom_range(0, 4) == 0) begin
            ex = near_coord(n); ey = near_coord(n); ez = near_coord(n);
        end else begin
            ex = px + $urandom_range(0, 4);
            ey = py + $urandom_range(0, 4);
            ez = pz + $urandom_range(0, 4);
        end
        send_command(pack_cmd(cmd, px, py, pz, ex, ey, ez,
                              pick_reach(), pick_reach(), pick_reach()));
    endtask

    initial begin
        int n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cycle_count   = 0;
        calm          = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full grid after reset: cleared store, edges, unknown command, whole-grid cut
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_VOXEL, 31, 31, 31, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 31, 31, 31, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, -1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 32, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command({64{1'b1}});
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_UNKNOWN_LO, 1, 1, 1, 5, 5, 5, 3, 3, 3));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_CUT_BOX,
                              -64, -64, -64, 63, 63, 63, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 31, 31, 31, 0, 0, 0, 0, 0, 0));
        drain_results();

        // small grid, darkest pen
        set_grid(5, 4, 6);
        set_pen(0, 0, 0, 0);
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_BOX, 3, 0, 0, 1, 3, 3, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_BOX, 0, 0, 0, 4, 3, 5, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_SPHERE, 2, 2, 2, 0, 0, 0, 0, 5, 5));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_ELLIPSOID, 2, 2, 2, 0, 0, 0, 3, 0, 3));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_ELLIPSOID, 2, 2, 2, 0, 0, 0, 2, 1, 3));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_CUT_SPHERE, 2, 2, 2, 0, 0, 0, 2, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 2, 2, 2, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_CUT_VOXEL,
                              -64, -64, -64, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_SPHERE, 63, 63, 63, 0, 0, 0, 63, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_CUT_ELLIPSOID,
                              -64, -64, -64, 0, 0, 0, 63, 63, 63));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 4, 3, 5, 0, 0, 0, 0, 0, 0));
        drain_results();

        // zero extent: nothing lies in the grid
        set_grid(0, 3, 3);
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_BOX,
                              -64, -64, -64, 63, 63, 63, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_results();

        // oversized extent clips to the built grid
        set_grid(63, 63, 63);
        set_pen(255, 128, 1, 77);
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_PUT_VOXEL, 31, 0, 31, 0, 0, 0, 0, 0, 0));
        send_command(pack_cmd(tb_vsfe_cmd_pkg::CMD_READ_VOXEL, 31, 0, 31, 0, 0, 0, 0, 0, 0));
        drain_results();

        // random phases on small grids; one phase without gaps or stalls
        for (int ph = 0; ph < 5; ph++) begin
            n = $urandom_range(1, 8);
            set_grid(n, $urandom_range(1, 8), $urandom_range(1, 8));
            set_pen($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
            calm = (ph == 2);
            repeat (20) random_command(n);
            drain_results();
        end
        calm = 1'b0;

        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
